/* rtl/tun_pkg.sv */
// Package for the triangle unit normal block: widths, payload structs and the
// leading-zero count. Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tun_pkg;

  localparam int CoordBits = 16;
  localparam int EdgeW     = CoordBits + 1;
  localparam int ProdW     = 2 * EdgeW;
  localparam int CrossW    = ProdW + 1;
  localparam int MagW      = CrossW;
  localparam int NormW     = 31;
  localparam int SqW       = 2 * NormW;
  localparam int SumW      = SqW + 2;
  localparam int RootW     = SumW / 2;
  localparam int FracW     = 15;
  localparam int NumW      = NormW + FracW + 1;
  localparam int DenW      = RootW + 1;
  localparam int LzW       = $clog2(MagW + 1);
  localparam int OutW      = 16;

  // Values that ride beside the length computation.
  typedef struct packed {
    logic [2:0][NormW-1:0] s;
    logic [2:0]            neg;
    logic                  degen;
  } side_t;

  typedef struct packed {
    logic [2:0][OutW-1:0] n;
    logic                 degen;
  } res_t;

  function automatic logic [LzW-1:0] lzc(input logic [MagW-1:0] v);
    logic [LzW-1:0] n;
    logic           found;
    n     = LzW'(MagW);
    found = 1'b0;
    for (int i = MagW - 1; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = LzW'(MagW - 1 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

/* rtl/triangle_unit_normal.sv */
// Top level of the triangle unit normal: edges, cross product, normalizing
// shift, squares and the output skid stage. Depends on tun_pkg, tun_isqrt, tun_div.
//
//   channel  handshake                 payload
//   in       in_valid_i / in_stall_o    first_*, second_*, third_* (Q8.8)
//   out      out_valid_o / out_stall_i  normal_x/y/z (Q2.14), degenerate
//
// One triangle enters per cycle while in_stall_o is low. From acceptance to the
// result register: 8 front stages, 32 square-root stages and 16 divider stages.
// The whole pipeline advances together and halts only while the skid register
// holds a result, so in_stall_o is a flop. Reset clears all valid bits.
`timescale 1ns / 1ps
`default_nettype none

module triangle_unit_normal (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [tun_pkg::CoordBits-1:0] first_x_i,
  input  wire logic signed [tun_pkg::CoordBits-1:0] first_y_i,
  input  wire logic signed [tun_pkg::CoordBits-1:0] first_z_i,
  input  wire logic signed [tun_pkg::CoordBits-1:0] second_x_i,
  input  wire logic signed [tun_pkg::CoordBits-1:0] second_y_i,
  input  wire logic signed [tun_pkg::CoordBits-1:0] second_z_i,
  input  wire logic signed [tun_pkg::CoordBits-1:0] third_x_i,
  input  wire logic signed [tun_pkg::CoordBits-1:0] third_y_i,
  input  wire logic signed [tun_pkg::CoordBits-1:0] third_z_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [tun_pkg::OutW-1:0]          normal_x_o,
  output logic signed [tun_pkg::OutW-1:0]          normal_y_o,
  output logic signed [tun_pkg::OutW-1:0]          normal_z_o,
  output logic                                     degenerate_o
);

  localparam int CB = tun_pkg::CoordBits;

  logic en;
  logic [7:0] v_q;

  logic signed [tun_pkg::EdgeW-1:0]  ea_q [3];
  logic signed [tun_pkg::EdgeW-1:0]  eb_q [3];
  logic signed [tun_pkg::ProdW-1:0]  p_q  [6];
  logic signed [tun_pkg::CrossW-1:0] c_q  [3];
  logic [2:0][tun_pkg::MagW-1:0]     m3_q, m4_q;
  logic [2:0]                        n3_q, n4_q, n5_q, n6_q;
  logic [tun_pkg::LzW-1:0]           lz_q;
  logic                              d4_q, d5_q, d6_q;
  logic [2:0][tun_pkg::MagW+tun_pkg::NormW-1:0] sh4;
  logic [2:0][tun_pkg::NormW-1:0]    s5_q, s6_q;
  logic [2:0][tun_pkg::SqW-1:0]      sq_q;
  logic [tun_pkg::SumW-1:0]          sum_q;
  tun_pkg::side_t                    side7;

  logic                              sq_valid;
  logic                              pipe_valid_sqrt;
  logic [tun_pkg::RootW-1:0]         root;
  tun_pkg::side_t                    root_side;
  logic                              pipe_valid;
  logic [2:0][tun_pkg::FracW-1:0]    quo;
  logic [2:0]                        quo_neg;
  logic                              quo_degen;
  tun_pkg::res_t                     pipe_res;

  logic          out_valid_q, skid_valid_q;
  tun_pkg::res_t out_q, skid_q;
  logic          take, pipe_fire;

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[6:0], in_valid_i};
    end
  end

  // Putting the top bit at position 30 covers both shift directions.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh4[i] = {m4_q[i], tun_pkg::NormW'(0)} << lz_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ea_q[0] <= {second_x_i[CB-1], second_x_i} - {first_x_i[CB-1], first_x_i};
      ea_q[1] <= {second_y_i[CB-1], second_y_i} - {first_y_i[CB-1], first_y_i};
      ea_q[2] <= {second_z_i[CB-1], second_z_i} - {first_z_i[CB-1], first_z_i};
      eb_q[0] <= {third_x_i[CB-1], third_x_i} - {first_x_i[CB-1], first_x_i};
      eb_q[1] <= {third_y_i[CB-1], third_y_i} - {first_y_i[CB-1], first_y_i};
      eb_q[2] <= {third_z_i[CB-1], third_z_i} - {first_z_i[CB-1], first_z_i};

      p_q[0] <= ea_q[1] * eb_q[2];
      p_q[1] <= ea_q[2] * eb_q[1];
      p_q[2] <= ea_q[2] * eb_q[0];
      p_q[3] <= ea_q[0] * eb_q[2];
      p_q[4] <= ea_q[0] * eb_q[1];
      p_q[5] <= ea_q[1] * eb_q[0];

      for (int i = 0; i < 3; i++) begin
        c_q[i] <= $signed({p_q[2*i][tun_pkg::ProdW-1], p_q[2*i]})
                - $signed({p_q[2*i+1][tun_pkg::ProdW-1], p_q[2*i+1]});
      end

      for (int i = 0; i < 3; i++) begin
        n3_q[i] <= c_q[i][tun_pkg::CrossW-1];
        m3_q[i] <= c_q[i][tun_pkg::CrossW-1] ? tun_pkg::MagW'(-c_q[i])
                                             : tun_pkg::MagW'(c_q[i]);
      end

      // The OR of the magnitudes has the same bit length as the largest one.
      lz_q <= tun_pkg::lzc(m3_q[0] | m3_q[1] | m3_q[2]);
      d4_q <= (m3_q[0] | m3_q[1] | m3_q[2]) == '0;
      m4_q <= m3_q;
      n4_q <= n3_q;

      for (int i = 0; i < 3; i++) begin
        s5_q[i] <= sh4[i][tun_pkg::MagW+tun_pkg::NormW-1 -: tun_pkg::NormW];
      end
      n5_q <= n4_q;
      d5_q <= d4_q;

      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= s5_q[i] * s5_q[i];
      end
      s6_q <= s5_q;
      n6_q <= n5_q;
      d6_q <= d5_q;

      sum_q <= tun_pkg::SumW'(sq_q[0]) + tun_pkg::SumW'(sq_q[1])
             + tun_pkg::SumW'(sq_q[2]);
      side7.s     <= s6_q;
      side7.neg   <= n6_q;
      side7.degen <= d6_q;
    end
  end

  assign sq_valid = v_q[7];

  tun_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .sum_i   (sum_q),
    .side_i  (side7),
    .valid_o (pipe_valid_sqrt),
    .root_o  (root),
    .side_o  (root_side)
  );

  tun_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pipe_valid_sqrt),
    .len_i   (root),
    .side_i  (root_side),
    .valid_o (pipe_valid),
    .quo_o   (quo),
    .neg_o   (quo_neg),
    .degen_o (quo_degen)
  );

  always_comb begin
    pipe_res.degen = quo_degen;
    for (int i = 0; i < 3; i++) begin
      if (quo_degen) begin
        pipe_res.n[i] = '0;
      end else if (quo_neg[i]) begin
        pipe_res.n[i] = -tun_pkg::OutW'(quo[i]);
      end else begin
        pipe_res.n[i] = tun_pkg::OutW'(quo[i]);
      end
    end
  end

  assign take      = out_valid_q && !out_stall_i;
  assign pipe_fire = pipe_valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || take) begin
      out_valid_q  <= skid_valid_q || pipe_fire;
      skid_valid_q <= 1'b0;
    end else if (pipe_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (pipe_fire) begin
        out_q <= pipe_res;
      end
    end else if (pipe_fire) begin
      skid_q <= pipe_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign normal_x_o   = out_q.n[0];
  assign normal_y_o   = out_q.n[1];
  assign normal_z_o   = out_q.n[2];
  assign degenerate_o = out_q.degen;

`ifndef SYNTHESIS
  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the output is empty");

  a_skid_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("skid result lost while the output was stalled");

  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |->
      (normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0))
    else $error("degenerate result with a nonzero normal");

  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (normal_x_o >= -16384 && normal_x_o <= 16384 &&
       normal_y_o >= -16384 && normal_y_o <= 16384 &&
       normal_z_o >= -16384 && normal_z_o <= 16384))
    else $error("normal component outside unit range");
`endif

endmodule

`default_nettype wire

/* rtl/tun_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with a sideband
// that travels with each item. Depends on tun_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tun_isqrt (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire logic [tun_pkg::SumW-1:0] sum_i,
  input  wire tun_pkg::side_t          side_i,
  output logic                         valid_o,
  output logic [tun_pkg::RootW-1:0]    root_o,
  output tun_pkg::side_t               side_o
);

  logic [tun_pkg::RootW-1:0]  vld_q;
  logic [tun_pkg::SumW-1:0]   rem_q  [tun_pkg::RootW];
  logic [tun_pkg::RootW-1:0]  root_q [tun_pkg::RootW];
  tun_pkg::side_t             side_q [tun_pkg::RootW];

  for (genvar k = 0; k < tun_pkg::RootW; k++) begin : g_stage
    localparam int B = tun_pkg::RootW - 1 - k;
    logic                       vld_in;
    logic [tun_pkg::SumW-1:0]   rem_in;
    logic [tun_pkg::RootW-1:0]  root_in;
    tun_pkg::side_t             side_in;
    logic [tun_pkg::SumW+1:0]   cand;
    logic [tun_pkg::SumW-1:0]   rem_d;
    logic [tun_pkg::RootW-1:0]  root_d;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = sum_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Trial subtraction of (2r + 2^B) * 2^B from the remainder.
    always_comb begin
      cand = ((tun_pkg::SumW + 2)'(root_in) << (B + 1))
           + ((tun_pkg::SumW + 2)'(1) << (2 * B));
      if ({2'b00, rem_in} >= cand) begin
        rem_d  = rem_in - cand[tun_pkg::SumW-1:0];
        root_d = root_in | (tun_pkg::RootW'(1) << B);
      end else begin
        rem_d  = rem_in;
        root_d = root_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[tun_pkg::RootW-1];
  assign root_o  = root_q[tun_pkg::RootW-1];
  assign side_o  = side_q[tun_pkg::RootW-1];

endmodule

`default_nettype wire

/* rtl/tun_div.sv */
// Pipelined restoring divider that scales the three components by the
// length, one quotient bit per stage for all three at once. Depends on tun_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tun_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire logic [tun_pkg::RootW-1:0] len_i,
  input  wire tun_pkg::side_t           side_i,
  output logic                          valid_o,
  output logic [2:0][tun_pkg::FracW-1:0] quo_o,
  output logic [2:0]                    neg_o,
  output logic                          degen_o
);

  localparam int Stages = tun_pkg::FracW + 1;

  logic [Stages-1:0]                  vld_q;
  logic [2:0][tun_pkg::NumW-1:0]      rem_q [Stages];
  logic [2:0][tun_pkg::FracW-1:0]     quo_q [Stages];
  logic [tun_pkg::DenW-1:0]           den_q [Stages];
  logic [2:0]                         neg_q [Stages];
  logic                               dgn_q [Stages];

  // Setup stage: numerator s * 2^15 + L, divisor 2L.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        rem_q[0][i] <= tun_pkg::NumW'({side_i.s[i], tun_pkg::FracW'(0)})
                     + tun_pkg::NumW'(len_i);
      end
      quo_q[0] <= '0;
      den_q[0] <= {len_i, 1'b0};
      neg_q[0] <= side_i.neg;
      dgn_q[0] <= side_i.degen;
    end
  end

  for (genvar k = 1; k < Stages; k++) begin : g_stage
    localparam int B = tun_pkg::FracW - k;
    logic [tun_pkg::NumW:0]           dsh;
    logic [2:0][tun_pkg::NumW-1:0]    rem_d;
    logic [2:0][tun_pkg::FracW-1:0]   quo_d;

    always_comb begin
      dsh = (tun_pkg::NumW + 1)'(den_q[k-1]) << B;
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, rem_q[k-1][i]} >= dsh) begin
          rem_d[i] = rem_q[k-1][i] - dsh[tun_pkg::NumW-1:0];
          quo_d[i] = quo_q[k-1][i] | (tun_pkg::FracW'(1) << B);
        end else begin
          rem_d[i] = rem_q[k-1][i];
          quo_d[i] = quo_q[k-1][i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        dgn_q[k] <= dgn_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Stages-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign quo_o   = quo_q[Stages-1];
  assign neg_o   = neg_q[Stages-1];
  assign degen_o = dgn_q[Stages-1];

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for triangle_unit_normal: a directed table, then random triangles.
// Results are checked against a face-normal predictor or typed rows; needs tun_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic signed [tun_pkg::OutW-1:0] nx, ny, nz;
    logic                            degen;
  } normal_t;

  typedef struct {
    logic signed [tun_pkg::CoordBits-1:0] v [9];
    bit                                   typed;
    normal_t                              want;
  } tri_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [tun_pkg::CoordBits-1:0] vert [9];
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [tun_pkg::OutW-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic degenerate_o;

  normal_t  normal_q [$];
  bit       typed_flag_q [$];
  normal_t  typed_want_q [$];
  int       mismatches = 0;
  bit       hold_done = 1'b0;
  tri_row_t rows [$];

  initial begin
    for (int i = 0; i < 9; i++) vert[i] = '0;
  end

  triangle_unit_normal dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .first_x_i(vert[0]), .first_y_i(vert[1]), .first_z_i(vert[2]),
    .second_x_i(vert[3]), .second_y_i(vert[4]), .second_z_i(vert[5]),
    .third_x_i(vert[6]), .third_y_i(vert[7]), .third_z_i(vert[8]),
    .out_valid_o, .out_stall_i, .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic longint unsigned root_floor(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic normal_t face_normal(input logic signed [tun_pkg::CoordBits-1:0] v [9]);
    longint a [3], b [3], c [3];
    longint unsigned m [3], big, s [3], sum, len, q [3];
    int n;
    normal_t r;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'(v[3+i]) - longint'(v[i]);
      b[i] = longint'(v[6+i]) - longint'(v[i]);
    end
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    big = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? longint'(-c[i]) : c[i];
      if (m[i] > big) big = m[i];
    end
    if (big == 0) begin
      r = '{nx: 0, ny: 0, nz: 0, degen: 1'b1};
      return r;
    end
    n = 0;
    while (big != 0) begin
      n++;
      big >>= 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      s[i] = n > 31 ? m[i] >> (n - 31) : m[i] << (31 - n);
      sum += s[i] * s[i];
    end
    len = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q[i] = ((s[i] << 15) + len) / (len << 1);
      if (c[i] < 0) q[i] = -q[i];
    end
    r.nx = q[0][tun_pkg::OutW-1:0];
    r.ny = q[1][tun_pkg::OutW-1:0];
    r.nz = q[2][tun_pkg::OutW-1:0];
    r.degen = 1'b0;
    return r;
  endfunction

  // Predict on every accepted input transaction; typed rows override the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      normal_t e;
      e = face_normal(vert);
      if (typed_flag_q.pop_front()) e = typed_want_q.pop_front();
      normal_q.push_back(e);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      normal_t e;
      if (normal_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction at %0t", $realtime);
      end else begin
        e = normal_q.pop_front();
        if (e.nx !== normal_x_o || e.ny !== normal_y_o || e.nz !== normal_z_o
            || e.degen !== degenerate_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                     e.nx, e.ny, e.nz, e.degen, normal_x_o, normal_y_o, normal_z_o,
                     degenerate_o);
        end
      end
    end
  end

  // Receiver: random stall bursts, and one long hold-off once traffic is flowing.
  initial begin
    int run;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && normal_q.size() > 20) begin
        out_stall_i <= 1'b1;
        for (int k = 0; k < 400; k++) @(posedge clk_i);
        hold_done = 1'b1;
      end
      run = $urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 4);
      out_stall_i <= ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 7) == 0) out_stall_i <= 1'b0;
      repeat (run) @(posedge clk_i);
    end
  end

  task automatic send_tri(input tri_row_t t);
    typed_flag_q.push_back(t.typed);
    if (t.typed) typed_want_q.push_back(t.want);
    in_valid_i <= 1'b1;
    for (int i = 0; i < 9; i++) vert[i] <= t.v[i];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic idle_gap();
    int g;
    g = $urandom_range(0, 19) == 0 ? $urandom_range(10, 50) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic tri_row_t mk(input int p [9], input bit typed, input normal_t w);
    tri_row_t t;
    for (int i = 0; i < 9; i++) t.v[i] = p[i][tun_pkg::CoordBits-1:0];
    t.typed = typed;
    t.want = w;
    return t;
  endfunction

  initial begin
    tri_row_t t;
    normal_t none, deg;
    int kind, base;
    none = '{nx: 0, ny: 0, nz: 0, degen: 1'b0};
    deg = '{nx: 0, ny: 0, nz: 0, degen: 1'b1};
    rows.push_back(mk('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, deg));
    rows.push_back(mk('{0, 0, 0, 256, 0, 0, 0, 256, 0}, 1, '{0, 0, 16384, 1'b0}));
    rows.push_back(mk('{0, 0, 0, 0, 256, 0, 256, 0, 0}, 1, '{0, 0, -16384, 1'b0}));
    rows.push_back(mk('{0, 0, 0, 0, 256, 0, 0, 0, 256}, 1, '{16384, 0, 0, 1'b0}));
    rows.push_back(mk('{0, 0, 0, 0, 0, 256, 256, 0, 0}, 1, '{0, 16384, 0, 1'b0}));
    rows.push_back(mk('{-32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767},
                      1, deg));
    rows.push_back(mk('{-32768, -32768, -32768, -32768, -32768, -32768, 5, 6, 7}, 1, deg));
    // Collinear vertices.
    rows.push_back(mk('{1, 2, 3, 3, 6, 9, -1, -2, -3}, 1, deg));
    rows.push_back(mk('{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768},
                      0, none));
    rows.push_back(mk('{32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768},
                      0, none));
    rows.push_back(mk('{-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767},
                      0, none));
    rows.push_back(mk('{0, 0, 0, 1, 0, 0, 0, 1, 0}, 0, none));
    rows.push_back(mk('{0, 0, 0, 1, 1, 1, 1, 2, 3}, 0, none));
    rows.push_back(mk('{100, -200, 300, 101, -199, 302, 99, -198, 297}, 0, none));
    rows.push_back(mk('{-1, -1, -1, 32767, 0, 0, 0, -32768, 0}, 0, none));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) begin
      send_tri(rows[r]);
      idle_gap();
    end

    for (int it = 0; it < 1900; it++) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) t.v[i] = tun_pkg::CoordBits'($urandom());
      if (kind < 3) begin
        // Small triangles around a random anchor.
        for (int i = 3; i < 9; i++) begin
          base = int'(t.v[i%3]) + int'($urandom_range(0, 64)) - 32;
          t.v[i] = base[tun_pkg::CoordBits-1:0];
        end
      end else if (kind == 3) begin
        for (int i = 0; i < 3; i++) t.v[6+i] = t.v[3+i];
      end else if (kind == 4) begin
        for (int i = 0; i < 3; i++) t.v[3+i] = t.v[i];
      end
      t.typed = 1'b0;
      send_tri(t);
      if (it == 950) begin
        in_valid_i <= 1'b0;
        while (normal_q.size() != 0) @(posedge clk_i);
      end
      idle_gap();
    end
    in_valid_i <= 1'b0;

    while (normal_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tun_pkg.sv
rtl/tun_isqrt.sv
rtl/tun_div.sv
rtl/triangle_unit_normal.sv
tb/tb.sv
